// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define SOR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sor assertion failed");

// condition must never be seen out of reset
`define SOR_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("sor forbidden condition seen");

`else

`define SOR_ASSERT(label, clk, rstn, prop)
`define SOR_NEVER(label, clk, rstn, cond)

`endif

`endif

// ===== hw/rtl/sor_pkg.sv =====
// types, register codes and helpers for the spiral order readout
package sor_pkg;

    localparam int ELEM_W = 32;
    localparam int SIZE_W = 4;
    localparam int IDX_W  = 3;
    localparam int CNT_W  = 7;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic [SIZE_W-1:0]        size_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic [1:0]               reg_index_t;

    localparam reg_index_t REG_ROWS = 2'd0;
    localparam reg_index_t REG_COLS = 2'd1;

    localparam size_t SIZE_RESET = 4'd4;

    typedef enum logic {
        ST_LOAD,
        ST_READ
    } state_t;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } dir_t;

    // one spiral position handed from the sequencer to the read stage
    typedef struct packed {
        idx_t row;
        idx_t col;
        logic last;
    } coord_t;

    // zero counts as one, anything above the maximum saturates
    function automatic size_t clamp_size(size_t v, size_t maxv);
        size_t r;
        r = v;
        if (v == '0) begin
            r = size_t'(1);
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/sor_seq.sv =====
// spiral coordinate sequencer: one matrix position per step
module sor_seq import sor_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   start,
    input  size_t  rows,
    input  size_t  cols,
    input  logic   step,
    output logic   busy,
    output coord_t coord
);

    logic   busy_reg, busy_next;
    dir_t   dir_reg, dir_next;
    idx_t   row_reg, row_next;
    idx_t   col_reg, col_next;
    idx_t   top_reg, top_next;
    idx_t   bottom_reg, bottom_next;
    idx_t   left_reg, left_next;
    idx_t   right_reg, right_next;
    count_t remain_reg, remain_next;
    logic [2*SIZE_W-1:0] total;

    assign total = (2*SIZE_W)'(rows) * (2*SIZE_W)'(cols);

    always_comb begin
        busy_next   = busy_reg;
        dir_next    = dir_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        remain_next = remain_reg;
        if (start) begin
            busy_next   = 1'b1;
            dir_next    = DIR_RIGHT;
            row_next    = '0;
            col_next    = '0;
            top_next    = '0;
            left_next   = '0;
            bottom_next = idx_t'(rows - size_t'(1));
            right_next  = idx_t'(cols - size_t'(1));
            remain_next = count_t'(total - (2*SIZE_W)'(1));
        end else if (step && busy_reg) begin
            if (remain_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                remain_next = remain_reg - count_t'(1);
                // walk the current side, turn and shrink at its end
                case (dir_reg)
                    DIR_RIGHT: begin
                        if (col_reg < right_reg) begin
                            col_next = col_reg + idx_t'(1);
                        end else begin
                            top_next = top_reg + idx_t'(1);
                            row_next = row_reg + idx_t'(1);
                            dir_next = DIR_DOWN;
                        end
                    end
                    DIR_DOWN: begin
                        if (row_reg < bottom_reg) begin
                            row_next = row_reg + idx_t'(1);
                        end else begin
                            right_next = right_reg - idx_t'(1);
                            col_next   = col_reg - idx_t'(1);
                            dir_next   = DIR_LEFT;
                        end
                    end
                    DIR_LEFT: begin
                        if (col_reg > left_reg) begin
                            col_next = col_reg - idx_t'(1);
                        end else begin
                            bottom_next = bottom_reg - idx_t'(1);
                            row_next    = row_reg - idx_t'(1);
                            dir_next    = DIR_UP;
                        end
                    end
                    DIR_UP: begin
                        if (row_reg > top_reg) begin
                            row_next = row_reg - idx_t'(1);
                        end else begin
                            left_next = left_reg + idx_t'(1);
                            col_next  = col_reg + idx_t'(1);
                            dir_next  = DIR_RIGHT;
                        end
                    end
                    default: begin
                        dir_next = DIR_RIGHT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            dir_reg  <= DIR_RIGHT;
        end else begin
            busy_reg <= busy_next;
            dir_reg  <= dir_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg    <= row_next;
        col_reg    <= col_next;
        top_reg    <= top_next;
        bottom_reg <= bottom_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        remain_reg <= remain_next;
    end

    assign busy       = busy_reg;
    assign coord.row  = row_reg;
    assign coord.col  = col_reg;
    assign coord.last = (remain_reg == '0);

endmodule

// ===== hw/rtl/spiral_order_readout.sv =====
// top level of the spiral order readout
// Loads a rows_used x cols_used matrix one element per transaction in row-major
// order into a single-port store, then streams every element back out in
// clockwise spiral order with its row, column and a last flag on the final
// one. Loading accepts one element per cycle while s_valid is high, and
// readout gives one result per cycle when the sink is ready; both rates are
// set by the one store port, which writes during loading and reads during
// readout. After the last element is accepted, the sequencer starts and each
// result passes the read stage and the output stage. While a matrix is read
// out, s_ready stays low; it rises again once the last read is issued, so the
// next matrix can load while the final results drain. Size writes go through
// cfg_we and restart any partial load; zero counts as one and sizes above
// MAX_ROWS or MAX_COLS saturate. Store contents need no clearing, every entry
// is written before it is read.
`include "assert_macros.svh"

module spiral_order_readout import sor_pkg::*; #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration writes
    input  logic       cfg_we,
    input  reg_index_t cfg_index,
    input  size_t      cfg_data,
    // element input
    input  logic       s_valid,
    output logic       s_ready,
    input  elem_t      s_element,
    // spiral output
    output logic       m_valid,
    input  logic       m_ready,
    output elem_t      m_element_out,
    output idx_t       m_row_index,
    output idx_t       m_col_index,
    output logic       m_last_of_run
);

    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LCNT_W   = $clog2(DEPTH + 1);
    localparam size_t MAX_ROWS_S = size_t'(MAX_ROWS);
    localparam size_t MAX_COLS_S = size_t'(MAX_COLS);

    // size registers, already clamped
    size_t rows_reg;
    size_t cols_reg;

    // load side
    logic [LCNT_W-1:0]   load_count_reg;
    logic [2*SIZE_W-1:0] total;
    logic                load_acc;
    logic                load_last;

    state_t state_reg, state_next;

    // matrix store, one synchronous read port
    elem_t mem [DEPTH];
    logic [2*SIZE_W-1:0] rd_lin;
    logic [ADDR_W-1:0]   rd_addr;

    // read stage and output stage
    logic   seq_busy;
    coord_t seq_coord;
    logic   issue;
    logic   out_free;
    logic   rd_valid_reg;
    coord_t rd_coord_reg;
    elem_t  rd_data_reg;
    logic   m_valid_reg;
    elem_t  m_element_reg;
    coord_t m_coord_reg;

    assign total     = (2*SIZE_W)'(rows_reg) * (2*SIZE_W)'(cols_reg);
    assign s_ready   = (state_reg == ST_LOAD);
    assign load_acc  = s_valid && s_ready;
    assign load_last = load_acc
                       && ((2*SIZE_W)'(load_count_reg) + (2*SIZE_W)'(1) == total);

    // config writes and load counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg       <= clamp_size(SIZE_RESET, MAX_ROWS_S);
            cols_reg       <= clamp_size(SIZE_RESET, MAX_COLS_S);
            load_count_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ROWS: begin
                    rows_reg       <= clamp_size(cfg_data, MAX_ROWS_S);
                    load_count_reg <= '0;
                end
                REG_COLS: begin
                    cols_reg       <= clamp_size(cfg_data, MAX_COLS_S);
                    load_count_reg <= '0;
                end
                default: begin
                    load_count_reg <= load_count_reg;
                end
            endcase
        end else if (load_acc) begin
            if (load_last) begin
                load_count_reg <= '0;
            end else begin
                load_count_reg <= load_count_reg + LCNT_W'(1);
            end
        end
    end

    // load until the last element, then read out the spiral
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (load_last) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (issue && seq_coord.last) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    sor_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (load_last),
        .rows    (rows_reg),
        .cols    (cols_reg),
        .step    (issue),
        .busy    (seq_busy),
        .coord   (seq_coord)
    );

    // while the sequencer is busy, a read is issued whenever the read stage is empty or moving on
    assign out_free = !m_valid_reg || m_ready;
    assign issue    = seq_busy && (!rd_valid_reg || out_free);

    // row-major address with stride cols_used
    assign rd_lin  = (2*SIZE_W)'(seq_coord.row) * (2*SIZE_W)'(cols_reg)
                     + (2*SIZE_W)'(seq_coord.col);
    assign rd_addr = rd_lin[ADDR_W-1:0];

    // store writes while loading and reads while reading out, never both
    always_ff @(posedge aclk) begin
        if (load_acc) begin
            mem[load_count_reg[ADDR_W-1:0]] <= s_element;
        end
        if (issue) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_coord_reg <= seq_coord;
        end
        if (rd_valid_reg && out_free) begin
            m_element_reg <= rd_data_reg;
            m_coord_reg   <= rd_coord_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= issue || (rd_valid_reg && !out_free);
            if (out_free) begin
                m_valid_reg <= rd_valid_reg;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_element_out = m_element_reg;
    assign m_row_index   = m_coord_reg.row;
    assign m_col_index   = m_coord_reg.col;
    assign m_last_of_run = m_coord_reg.last;

    // loading and readout never overlap on the store port
    `SOR_NEVER(a_no_load_in_read, aclk, aresetn, s_ready && seq_busy)
    // the last element starts the sequencer
    `SOR_ASSERT(a_start_busy, aclk, aresetn, load_last |=> seq_busy)
    // a stalled read stage keeps its entry
    `SOR_ASSERT(a_rd_hold, aclk, aresetn,
        rd_valid_reg && !out_free |=> rd_valid_reg && $stable(rd_coord_reg))
    // issuing the final position ends the readout
    `SOR_ASSERT(a_last_ends, aclk, aresetn,
        issue && seq_coord.last |=> !seq_busy && (state_reg == ST_LOAD))

endmodule
